>>> hw/rtl/ittf_pkg.sv
// Shared types, codes and constants of the integer to text formatter.
`default_nettype none

package ittf_pkg;

	// Width of the word field and of one ASCII character.
	localparam int unsigned INPUT_BITS = 32;
	localparam int unsigned CHAR_BITS  = 8;

	// ASCII codes and digit limits used when printing.
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [3:0]           DIGIT_TEN    = 4'hA;
	localparam logic [3:0]           DIGIT_MASK   = 4'hF;

	// Formatting modes carried in the operation field.
	typedef enum logic [1:0] {
		OP_SDEC = 2'd0,
		OP_UDEC = 2'd1,
		OP_HEX  = 2'd2,
		OP_BIN  = 2'd3
	} op_t;

	// Digit layout inside the shared digit register.
	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_HEX,
		RADIX_BIN
	} radix_t;

	// Step that the digit unit performs.
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_LOAD,
		CMD_DABBLE,
		CMD_SHIFT
	} cmd_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// Input beat: one word and its mode.
	typedef struct packed {
		logic [INPUT_BITS-1:0] value;
		logic [1:0]            operation;
	} in_beat_t;

	// Output beat: one character and the end-of-run flag.
	typedef struct packed {
		logic [CHAR_BITS-1:0] character;
		logic                 last;
	} out_beat_t;

	// Command from the sequencer to the digit unit.
	typedef struct packed {
		cmd_t   cmd;
		radix_t radix;
	} unit_ctrl_t;

	// Character handed from the sequencer to the output register.
	typedef struct packed {
		logic      valid;
		out_beat_t beat;
	} emit_t;

	// ASCII code of one digit, upper case for ten and above.
	function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] digit);
		logic [3:0] d;
		d = digit & DIGIT_MASK;
		if (d < DIGIT_TEN) begin
			return CHAR_ZERO + {4'd0, d};
		end
		return CHAR_UPPER_A + {4'd0, d - DIGIT_TEN};
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/integer_to_text_formatter.sv
// Top level of the integer to text formatter with its output register.
//
//   Channel | Direction | Handshake               | Beat
//   item    | in        | item_valid, item_ready  | ittf_pkg::in_beat_t (value, operation)
//   text    | out       | text_valid, text_ready  | ittf_pkg::out_beat_t (character, last)
//
// Decimal: the word is loaded and converted to BCD by double dabble over its WORD_BITS bits;
// then leading zero digits of the DEC_DIGITS are skipped (the last digit is always kept),
// a '-' is sent for a negative word, and the remaining digits are sent as characters.
// Hex and binary skip the conversion and work the same way on HEX_DIGITS and WORD_BITS digits.
// The shared digit register shifts out one digit per cycle unless the text channel stalls.
// Reset clears the sequencer and the output register; no clearing pass is needed.
// A stalled text channel holds the sequencer; a new word is taken while the last
// character still waits in the output register.
`default_nettype none

module integer_to_text_formatter #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire ittf_pkg::in_beat_t  item,
	output logic                     text_valid,
	input  wire logic                text_ready,
	output ittf_pkg::out_beat_t      text
);
	import ittf_pkg::*;

	// Only the word field's bits can be set, so wider settings print it unsigned.
	localparam int unsigned WORD_BITS  = (VALUE_BITS < INPUT_BITS) ? VALUE_BITS : INPUT_BITS;
	localparam bit          HAS_SIGN   = (VALUE_BITS <= INPUT_BITS);
	localparam int unsigned DEC_DIGITS = (WORD_BITS * 3) / 10 + 1;
	localparam int unsigned HEX_DIGITS = (WORD_BITS + 3) / 4;

	unit_ctrl_t           ctrl;
	logic [WORD_BITS-1:0] load_word;
	logic [3:0]           top_digit;
	emit_t                emit;
	logic                 out_free;
	logic                 text_valid_q;
	out_beat_t            text_q;

	assign out_free = !text_valid_q || text_ready;

	ittf_ctrl #(
		.WORD_BITS  (WORD_BITS),
		.DEC_DIGITS (DEC_DIGITS),
		.HEX_DIGITS (HEX_DIGITS),
		.HAS_SIGN   (HAS_SIGN)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_free   (out_free),
		.top_digit  (top_digit),
		.ctrl       (ctrl),
		.load_word  (load_word),
		.emit       (emit)
	);

	ittf_digit_unit #(
		.WORD_BITS  (WORD_BITS),
		.DEC_DIGITS (DEC_DIGITS),
		.HEX_DIGITS (HEX_DIGITS)
	) u_digit (
		.clk       (clk),
		.ctrl      (ctrl),
		.load_word (load_word),
		.top_digit (top_digit)
	);

	// Output register: holds one character beat until the text channel takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_q <= 1'b0;
		end else if (emit.valid) begin
			text_valid_q <= 1'b1;
		end else if (text_ready) begin
			text_valid_q <= 1'b0;
		end
	end

	// Payload of the output register.
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			text_q <= emit.beat;
		end
	end

	assign text_valid = text_valid_q;
	assign text       = text_q;

endmodule

`default_nettype wire

>>> hw/rtl/ittf_digit_unit.sv
// Shared digit register: binary to BCD conversion and digit shifting.
`default_nettype none

module ittf_digit_unit #(
	parameter int unsigned WORD_BITS  = 32,
	parameter int unsigned DEC_DIGITS = 10,
	parameter int unsigned HEX_DIGITS = 8
) (
	input  wire logic                   clk,
	input  wire ittf_pkg::unit_ctrl_t   ctrl,
	input  wire logic [WORD_BITS-1:0]   load_word,
	output logic [3:0]                  top_digit
);
	import ittf_pkg::*;

	// The decimal layout is the widest of the three for any supported width.
	localparam int unsigned DIG_BITS = 4 * DEC_DIGITS;
	localparam int unsigned HEX_PAD  = DIG_BITS - 4 * HEX_DIGITS;
	localparam int unsigned BIN_PAD  = DIG_BITS - WORD_BITS;

	logic [WORD_BITS-1:0] word_q;
	logic [DIG_BITS-1:0]  dig_q;
	logic [DIG_BITS-1:0]  adj;

	// Add three to every BCD digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (dig_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = dig_q[4*i +: 4];
			end
		end
	end

	// The digit register is loaded top aligned, so the next digit always sits at the top.
	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CMD_LOAD: begin
				word_q <= load_word;
				case (ctrl.radix)
					RADIX_HEX: dig_q <= DIG_BITS'(load_word) << HEX_PAD;
					RADIX_BIN: dig_q <= DIG_BITS'(load_word) << BIN_PAD;
					default:   dig_q <= '0;
				endcase
			end
			CMD_DABBLE: begin
				dig_q  <= {adj[DIG_BITS-2:0], word_q[WORD_BITS-1]};
				word_q <= {word_q[WORD_BITS-2:0], 1'b0};
			end
			CMD_SHIFT: begin
				if (ctrl.radix == RADIX_BIN) begin
					dig_q <= dig_q << 1;
				end else begin
					dig_q <= dig_q << 4;
				end
			end
			default: begin
			end
		endcase
	end

	// The digit at the top of the register.
	always_comb begin
		if (ctrl.radix == RADIX_BIN) begin
			top_digit = {3'd0, dig_q[DIG_BITS-1]};
		end else begin
			top_digit = dig_q[DIG_BITS-1 -: 4];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ittf_ctrl.sv
// Sequencer: takes a word, steps the digit unit and hands out characters.
`default_nettype none

module ittf_ctrl #(
	parameter int unsigned WORD_BITS  = 32,
	parameter int unsigned DEC_DIGITS = 10,
	parameter int unsigned HEX_DIGITS = 8,
	parameter bit          HAS_SIGN   = 1'b1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire ittf_pkg::in_beat_t     item,
	input  wire logic                   out_free,
	input  wire logic [3:0]             top_digit,
	output ittf_pkg::unit_ctrl_t        ctrl,
	output logic [WORD_BITS-1:0]        load_word,
	output ittf_pkg::emit_t             emit
);
	import ittf_pkg::*;

	localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

	state_t              state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	radix_t              radix_q, radix_d;
	logic                neg_q, neg_d;

	op_t                 in_op;
	radix_t              in_radix;
	logic [WORD_BITS-1:0] in_word;
	logic                in_neg;
	logic                cnt_one;

	// Decode the incoming beat.
	always_comb begin
		in_op   = op_t'(item.operation);
		in_word = item.value[WORD_BITS-1:0];
		in_neg  = HAS_SIGN && (in_op == OP_SDEC) && in_word[WORD_BITS-1];
		unique case (in_op) inside
			OP_SDEC, OP_UDEC: in_radix = RADIX_DEC;
			OP_HEX:           in_radix = RADIX_HEX;
			default:          in_radix = RADIX_BIN;
		endcase
	end

	assign cnt_one = (cnt_q == CNT_BITS'(1));

	// Next state and counters.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		radix_d = radix_q;
		neg_d   = neg_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					radix_d = in_radix;
					neg_d   = in_neg;
					unique case (in_radix)
						RADIX_DEC: begin
							state_d = ST_CONV;
							cnt_d   = CNT_BITS'(WORD_BITS);
						end
						RADIX_HEX: begin
							state_d = ST_SKIP;
							cnt_d   = CNT_BITS'(HEX_DIGITS);
						end
						default: begin
							state_d = ST_SKIP;
							cnt_d   = CNT_BITS'(WORD_BITS);
						end
					endcase
				end
			end
			ST_CONV: begin
				cnt_d = cnt_q - 1'b1;
				if (cnt_one) begin
					state_d = ST_SKIP;
					cnt_d   = CNT_BITS'(DEC_DIGITS);
				end
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && !cnt_one) begin
					cnt_d = cnt_q - 1'b1;
				end else if (neg_q) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cnt_d = cnt_q - 1'b1;
					if (cnt_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs: unit command, load word and character beat.
	always_comb begin
		item_ready       = 1'b0;
		ctrl.cmd         = CMD_HOLD;
		ctrl.radix       = radix_q;
		load_word        = in_neg ? WORD_BITS'(-in_word) : in_word;
		emit.valid       = 1'b0;
		emit.beat.character = digit_char(top_digit);
		emit.beat.last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				ctrl.radix = in_radix;
				if (item_valid) begin
					ctrl.cmd = CMD_LOAD;
				end
			end
			ST_CONV: begin
				ctrl.cmd = CMD_DABBLE;
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && !cnt_one) begin
					ctrl.cmd = CMD_SHIFT;
				end
			end
			ST_SIGN: begin
				emit.valid          = out_free;
				emit.beat.character = CHAR_MINUS;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit.valid     = 1'b1;
					emit.beat.last = cnt_one;
					ctrl.cmd       = CMD_SHIFT;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			radix_q <= RADIX_DEC;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			radix_q <= radix_d;
			neg_q   <= neg_d;
		end
	end

	// A character is only handed over when the output register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("character beat handed over while output register is full");

	// An accepted word always starts a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q != ST_IDLE))
		else $error("accepted word did not start a run");

	// The digit count never runs out while digits remain to be skipped or sent.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> (cnt_q != '0))
		else $error("digit count exhausted during skip or emit");

	// The final character of a run returns the sequencer to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.beat.last) |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after final character");

endmodule

`default_nettype wire
